/* rtl/etok_pkg.sv */
// Shared types, constants and character classification for the expression tokenizer.
package etok_pkg;

   // Default width of the line and column counters.
   localparam int POS_BITS_DEF = 16;

   // Reported positions are always this wide.
   localparam int OUT_POS_W = 16;

   // Result queue depth; must be a power of two and at least 2.
   localparam int QUEUE_DEPTH = 4;

   // Token kinds.
   localparam logic [3:0] KIND_IDENT  = 4'd0;
   localparam logic [3:0] KIND_INT    = 4'd1;
   localparam logic [3:0] KIND_PLUS   = 4'd2;
   localparam logic [3:0] KIND_MINUS  = 4'd3;
   localparam logic [3:0] KIND_TIMES  = 4'd4;
   localparam logic [3:0] KIND_DIVIDE = 4'd5;
   localparam logic [3:0] KIND_LPAREN = 4'd6;
   localparam logic [3:0] KIND_RPAREN = 4'd7;
   localparam logic [3:0] KIND_ERROR  = 4'd8;
   localparam logic [3:0] KIND_END    = 4'd9;

   // Characters with a meaning of their own.
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_TIMES   = 8'h2A;
   localparam logic [7:0] CHAR_DIVIDE  = 8'h2F;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   // One result item.
   typedef struct packed {
      logic [3:0]           token_kind;
      logic [7:0]           lexeme_char;
      logic [OUT_POS_W-1:0] start_line;
      logic [OUT_POS_W-1:0] start_col;
      logic                 first_char;
      logic                 last_char;
   } tok_type;

   // Up to two results pushed into the queue in one cycle; slot 1 is used only with slot 0.
   typedef struct packed {
      logic    valid0;
      logic    valid1;
      tok_type tok0;
      tok_type tok1;
   } push_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_TIMES ||
             c == CHAR_DIVIDE || c == CHAR_LPAREN || c == CHAR_RPAREN;
   endfunction

   function automatic logic [3:0] op_kind(input logic [7:0] c);
      logic [3:0] k;
      case (c)
         CHAR_PLUS:   k = KIND_PLUS;
         CHAR_MINUS:  k = KIND_MINUS;
         CHAR_TIMES:  k = KIND_TIMES;
         CHAR_DIVIDE: k = KIND_DIVIDE;
         CHAR_LPAREN: k = KIND_LPAREN;
         default:     k = KIND_RPAREN;
      endcase
      return k;
   endfunction

endpackage

/* rtl/etok_if.sv */
// Valid/ready channel interfaces for source bytes and tokens.
interface etok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_input;

   modport source (output valid, output char_in, output end_of_input, input ready);
   modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface etok_rsp_if import etok_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [3:0]           token_kind;
   logic [7:0]           lexeme_char;
   logic [OUT_POS_W-1:0] start_line;
   logic [OUT_POS_W-1:0] start_col;
   logic                 first_char;
   logic                 last_char;

   modport source (output valid, output token_kind, output lexeme_char, output start_line,
                   output start_col, output first_char, output last_char, input ready);
   modport sink   (input valid, input token_kind, input lexeme_char, input start_line,
                   input start_col, input first_char, input last_char, output ready);
endinterface

/* rtl/etok_front.sv */
// Scanner front end: accepts bytes, classifies them and pushes up to two tokens per byte.
module etok_front import etok_pkg::*; #(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   etok_req_if.sink      req_port,
   input  logic          space_ok,
   output push_type      push
);

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_IDENT = 2'd1;
   localparam logic [1:0] MODE_INT   = 2'd2;
   localparam logic [1:0] MODE_HALT  = 2'd3;

   logic [1:0]          mode_ff, mode_in;
   logic [7:0]          held_char_ff, held_char_in;
   logic                held_first_ff, held_first_in;
   logic [POS_BITS-1:0] tok_line_ff, tok_line_in;
   logic [POS_BITS-1:0] tok_col_ff, tok_col_in;
   logic [POS_BITS-1:0] line_ff, line_in;
   logic [POS_BITS-1:0] col_ff, col_in;

   logic                accept;
   logic [7:0]          c;
   logic                eoi;
   logic [POS_BITS-1:0] adv_line, adv_col;
   tok_type             slot [2];
   logic [1:0]          slot_v;

   // Clip a counter value to the reported width.
   function automatic logic [OUT_POS_W-1:0] pos_out(input logic [POS_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'(16'hFFFF)) ? 16'hFFFF : w[OUT_POS_W-1:0];
   endfunction

   function automatic tok_type make_tok(input logic [3:0] kind, input logic [7:0] ch,
                                        input logic [POS_BITS-1:0] ln,
                                        input logic [POS_BITS-1:0] cl,
                                        input logic first, input logic last);
      tok_type t;
      t.token_kind  = kind;
      t.lexeme_char = ch;
      t.start_line  = pos_out(ln);
      t.start_col   = pos_out(cl);
      t.first_char  = first;
      t.last_char   = last;
      return t;
   endfunction

   assign req_port.ready = space_ok;
   assign accept         = req_port.valid && space_ok;
   assign c              = req_port.char_in;
   assign eoi            = req_port.end_of_input;

   // Position of the byte after this one, saturating.
   always_comb begin
      adv_line = line_ff;
      adv_col  = col_ff;
      if (c == CHAR_NEWLINE) begin
         adv_col = POS_BITS'(1);
         if (!(&line_ff)) adv_line = line_ff + POS_BITS'(1);
      end else if (!(&col_ff)) begin
         adv_col = col_ff + POS_BITS'(1);
      end
   end

   // Scan step: flush or extend the run; after a flush or from idle, handle the byte as from idle.
   always_comb begin
      logic       k;
      logic       done;
      logic [3:0] run_kind;
      logic       cont;
      k             = 1'b0;
      done          = 1'b0;
      run_kind      = (mode_ff == MODE_IDENT) ? KIND_IDENT : KIND_INT;
      cont          = 1'b0;
      mode_in       = mode_ff;
      held_char_in  = held_char_ff;
      held_first_in = held_first_ff;
      tok_line_in   = tok_line_ff;
      tok_col_in    = tok_col_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      slot_v        = 2'b00;
      slot[0]       = make_tok(KIND_END, 8'h00, line_ff, col_ff, 1'b1, 1'b1);
      slot[1]       = slot[0];

      if (accept && mode_ff != MODE_HALT) begin
         if (mode_ff == MODE_IDENT || mode_ff == MODE_INT) begin
            cont = !eoi && ((mode_ff == MODE_IDENT) ? is_letter(c) : is_digit(c));
            slot[0]   = make_tok(run_kind, held_char_ff, tok_line_ff, tok_col_ff,
                                 held_first_ff, !cont);
            slot_v[0] = 1'b1;
            held_first_in = 1'b0;
            if (cont) begin
               held_char_in = c;
               line_in      = adv_line;
               col_in       = adv_col;
               done         = 1'b1;
            end else begin
               mode_in = MODE_IDLE;
               k       = 1'b1;
            end
         end

         if (!done) begin
            if (eoi) begin
               slot[k]   = make_tok(KIND_END, 8'h00, line_ff, col_ff, 1'b1, 1'b1);
               slot_v[k] = 1'b1;
               mode_in   = MODE_HALT;
            end else if (is_space(c)) begin
               line_in = adv_line;
               col_in  = adv_col;
            end else begin
               tok_line_in = line_ff;
               tok_col_in  = col_ff;
               if (is_letter(c) || is_digit(c)) begin
                  mode_in       = is_letter(c) ? MODE_IDENT : MODE_INT;
                  held_char_in  = c;
                  held_first_in = 1'b1;
                  line_in       = adv_line;
                  col_in        = adv_col;
               end else if (is_op(c)) begin
                  slot[k]   = make_tok(op_kind(c), c, line_ff, col_ff, 1'b1, 1'b1);
                  slot_v[k] = 1'b1;
                  line_in   = adv_line;
                  col_in    = adv_col;
               end else begin
                  slot[k]   = make_tok(KIND_ERROR, c, line_ff, col_ff, 1'b1, 1'b1);
                  slot_v[k] = 1'b1;
                  mode_in   = MODE_HALT;
               end
            end
         end
      end
   end

   assign push.valid0 = slot_v[0];
   assign push.valid1 = slot_v[1];
   assign push.tok0   = slot[0];
   assign push.tok1   = slot[1];

   // Scanner state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         held_char_ff  <= 8'h00;
         held_first_ff <= 1'b0;
         tok_line_ff   <= POS_BITS'(1);
         tok_col_ff    <= POS_BITS'(1);
         line_ff       <= POS_BITS'(1);
         col_ff        <= POS_BITS'(1);
      end else begin
         mode_ff       <= mode_in;
         held_char_ff  <= held_char_in;
         held_first_ff <= held_first_in;
         tok_line_ff   <= tok_line_in;
         tok_col_ff    <= tok_col_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
      end
   end

endmodule

/* rtl/etok_queue.sv */
// Token queue back end: takes up to two tokens a cycle and, while rsp is ready, delivers one a cycle.
module etok_queue import etok_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       space_ok,
   etok_rsp_if.source rsp_port
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tok_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;
   logic [1:0]         push_n;
   tok_type            head;

   // Room for the two tokens one byte can cause.
   assign space_ok = count_ff <= CNT_W'(QUEUE_DEPTH - 2);

   assign pop    = rsp_port.valid && rsp_port.ready;
   assign push_n = {1'b0, push.valid0} + {1'b0, push.valid1};

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Token storage.
   always_ff @(posedge clock) begin
      if (push.valid0) entry_ff[wr_ptr_ff] <= push.tok0;
      if (push.valid1) entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.tok1;
   end

   // Head of the queue drives the result channel.
   assign head                 = entry_ff[rd_ptr_ff];
   assign rsp_port.valid       = count_ff != '0;
   assign rsp_port.token_kind  = head.token_kind;
   assign rsp_port.lexeme_char = head.lexeme_char;
   assign rsp_port.start_line  = head.start_line;
   assign rsp_port.start_col   = head.start_col;
   assign rsp_port.first_char  = head.first_char;
   assign rsp_port.last_char   = head.last_char;

endmodule

/* rtl/expression_tokenizer_top.sv */
// Expression tokenizer: one source byte per req transaction, one token character per rsp
// transaction.
//
// Each req transaction carries one ASCII byte, or an end-of-input mark. White space is
// skipped; letter runs become identifiers, digit runs integers, and + - * / ( ) single
// character tokens. Every lexeme character comes out as one rsp transaction with its
// kind, start line and column and first/last flags.
// A run character is held until the next byte shows whether it ends the run, so its
// token appears one req transaction later; all other tokens are written to the token
// queue when their byte is accepted. One byte gives at most two tokens.
// Throughput is one byte per cycle while the queue has room. The scanner accepts a byte whenever
// the four-entry token queue has room for two tokens, so it keeps taking bytes while a token waits
// on a stalled rsp; a long rsp stall fills the queue and then holds req ready low.
// An unrecognized byte gives an error token, end of input gives an end token; after
// either, further bytes are accepted and dropped until reset.
// Synchronous reset empties the queue and sets line and column to 1.
module expression_tokenizer_top import etok_pkg::*; #(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   etok_req_if.sink   req_port,
   etok_rsp_if.source rsp_port
);

   push_type push;
   logic     space_ok;

   etok_front #(.POS_BITS(POS_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .space_ok (space_ok),
      .push     (push)
   );

   etok_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_port (rsp_port)
   );

   // A second token in one cycle only follows a first.
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      push.valid1 |-> push.valid0)
      else $error("second token pushed without first");

   // Tokens are pushed only for accepted bytes, and only when the queue has room.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.valid0 |-> (space_ok && req_port.valid))
      else $error("token pushed without an accepted byte");

   // Error and end tokens are complete single-character tokens.
   a_term_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && (rsp_port.token_kind == KIND_ERROR ||
                          rsp_port.token_kind == KIND_END))
      |-> (rsp_port.first_char && rsp_port.last_char))
      else $error("error or end token without both flags");

   // Reset leaves no token pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_port.valid)
      else $error("token pending after reset");

endmodule
